// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- sv/lgge_pkg.sv -----
// shared types and constants of the life grid generation engine
`default_nettype none
package lgge_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 5;
  localparam int TICK_W = 16;

  localparam logic [TICK_W-1:0] TICKS_RESET = 16'd15;
  localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;

  // neighbor counts of rule b3/s23
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_START = 3'd1,
    CMD_PAUSE = 3'd2,
    CMD_TICK  = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_TICKS = 1'b0,
    CFG_WRAP  = 1'b1
  } cfg_idx_t;

endpackage
`default_nettype wire

// ----- sv/lgge_cell.sv -----
// one column cell: three-row window and the b3/s23 rule
`default_nettype none
module lgge_cell
  import lgge_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic       bit_in,
  input  wire logic [2:0] win_l,
  input  wire logic [2:0] win_r,
  output logic [2:0]      win_o,
  output logic            alive_nxt
);

  logic top_r, mid_r, bot_r;
  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      top_r <= mid_r;
      mid_r <= bot_r;
      bot_r <= bit_in;
    end
  end

  assign win_o = {bot_r, mid_r, top_r};

  assign count = {3'b0, win_l[0]} + {3'b0, win_l[1]} + {3'b0, win_l[2]}
               + {3'b0, win_r[0]} + {3'b0, win_r[1]} + {3'b0, win_r[2]}
               + {3'b0, top_r} + {3'b0, bot_r};

  assign alive_nxt = (count == BIRTH_COUNT) || (mid_r && (count == SURVIVE_COUNT));

endmodule
`default_nettype wire

// ----- sv/lgge_row_chain.sv -----
// row of column cells that turns three grid rows into one new row
`default_nettype none
module lgge_row_chain
  import lgge_pkg::*;
#(
  parameter int GRID_WIDTH = GRID_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  shift_en,
  input  wire logic                  wrap,
  input  wire logic [GRID_WIDTH-1:0] row_in,
  output logic [GRID_WIDTH-1:0]      row_out
);

  logic [2:0] win [GRID_WIDTH];

  for (genvar i = 0; i < GRID_WIDTH; i++) begin : g_cell
    logic [2:0] left_w, right_w;

    if (i == 0) begin : g_left_edge
      assign left_w = wrap ? win[GRID_WIDTH-1] : 3'b000;
    end else begin : g_left
      assign left_w = win[i-1];
    end

    if (i == GRID_WIDTH - 1) begin : g_right_edge
      assign right_w = wrap ? win[0] : 3'b000;
    end else begin : g_right
      assign right_w = win[i+1];
    end

    lgge_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .bit_in   (row_in[i]),
      .win_l    (left_w),
      .win_r    (right_w),
      .win_o    (win[i]),
      .alive_nxt(row_out[i])
    );
  end

endmodule
`default_nettype wire

// ----- sv/life_grid_generation_engine.sv -----
// top level: grid memory, command sequencer and generation sweep
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_cmd, in_col, in_row, in_alive_in
//  out      output     out_valid / out_ready  out_cell_alive, out_running,
//                                             out_advanced, out_all_dead
//  cfg      input      cfg_we                 cfg_index, cfg_wdata
//
// a generating tick steps each row through the cell chain in a shift state
// and then a write state. one word is taken at a time; the next is taken while
// the last result waits. rows carry valid bits, so reset needs no clearing pass.
`include "assert_macros.svh"
`default_nettype none
module life_grid_generation_engine
  import lgge_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [COL_W-1:0]  in_col,
  input  wire logic [ROW_W-1:0]  in_row,
  input  wire logic              in_alive_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_cell_alive,
  output logic                   out_running,
  output logic                   out_advanced,
  output logic                   out_all_dead,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [TICK_W-1:0] cfg_wdata
);

  localparam int RW  = $clog2(GRID_HEIGHT);
  localparam int CW  = $clog2(GRID_WIDTH);
  localparam int NZW = $clog2(GRID_HEIGHT + 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_EXEC = 11'b000_0000_0010,
    S_WMOD = 11'b000_0000_0100,
    S_G0   = 11'b000_0000_1000,
    S_G1   = 11'b000_0001_0000,
    S_G2   = 11'b000_0010_0000,
    S_GSH  = 11'b000_0100_0000,
    S_GWR  = 11'b000_1000_0000,
    S_CHK  = 11'b001_0000_0000,
    S_RD   = 11'b010_0000_0000,
    S_RESP = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // latched word
  cmd_t             cmd_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             alive_r;

  logic              run_r, run_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [TICK_W-1:0] period_r;
  logic              wrap_r;
  logic [RW-1:0]     y_r, y_nxt, y_p1;
  logic              adv_r, adv_nxt;
  logic              dead_r, dead_nxt;

  logic [GRID_WIDTH-1:0] first_row_r;
  logic                  first_ld;

  // grid memory, one row per word
  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] mem_q_r;
  logic                  q_vld_r;
  logic                  mem_re, mem_we;
  logic [RW-1:0]         mem_raddr, mem_waddr;
  logic [GRID_WIDTH-1:0] mem_wdata;
  logic [GRID_HEIGHT-1:0] row_valid_r;
  logic [GRID_HEIGHT-1:0] row_nz_r;
  logic [NZW-1:0]         nz_cnt_r;
  logic                   wr_nz;

  logic [GRID_WIDTH-1:0] q_row, edit_row, chain_in, chain_out;
  logic                  shift_en;

  logic [RW-1:0] cell_row;
  logic [CW-1:0] cell_col;
  logic          in_grid;
  logic          cell_bit;

  logic out_valid_r, out_ld;
  logic out_cell_alive_r, out_running_r, out_advanced_r, out_all_dead_r;

  assign cell_row = RW'(row_r);
  assign cell_col = CW'(col_r);
  assign in_grid  = (32'(col_r) < 32'(GRID_WIDTH)) && (32'(row_r) < 32'(GRID_HEIGHT));
  assign q_row    = q_vld_r ? mem_q_r : '0;
  assign cell_bit = in_grid && q_row[cell_col];
  assign tick_inc = (tick_r == TICK_MAX) ? tick_r : tick_r + 16'd1;
  assign y_p1     = y_r + RW'(1);
  assign wr_nz    = |mem_wdata;

  always_comb begin
    edit_row           = q_row;
    edit_row[cell_col] = alive_r;
  end

  assign in_ready = (state_r == S_IDLE);

  lgge_row_chain #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_chain (
    .clk     (clk),
    .shift_en(shift_en),
    .wrap    (wrap_r),
    .row_in  (chain_in),
    .row_out (chain_out)
  );

  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    tick_nxt  = tick_r;
    y_nxt     = y_r;
    adv_nxt   = adv_r;
    dead_nxt  = dead_r;
    mem_re    = 1'b0;
    mem_raddr = cell_row;
    mem_we    = 1'b0;
    mem_waddr = cell_row;
    mem_wdata = edit_row;
    shift_en  = 1'b0;
    chain_in  = q_row;
    first_ld  = 1'b0;
    out_ld    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        adv_nxt  = 1'b0;
        dead_nxt = 1'b0;
        case (cmd_r)
          CMD_WRITE: begin
            if (!run_r && in_grid) begin
              mem_re    = 1'b1;
              state_nxt = S_WMOD;
            end else begin
              state_nxt = S_RD;
            end
          end
          CMD_START: begin
            run_nxt   = 1'b1;
            state_nxt = S_RD;
          end
          CMD_PAUSE: begin
            if (run_r) begin
              run_nxt  = 1'b0;
              tick_nxt = '0;
            end
            state_nxt = S_RD;
          end
          CMD_TICK: begin
            if (!run_r) begin
              state_nxt = S_RD;
            end else if (tick_inc >= period_r) begin
              tick_nxt  = '0;
              state_nxt = S_G0;
            end else begin
              tick_nxt  = tick_inc;
              state_nxt = S_CHK;
            end
          end
          default: begin
            state_nxt = S_RD;
          end
        endcase
      end
      S_WMOD: begin
        mem_we    = 1'b1;
        state_nxt = S_RD;
      end
      S_G0: begin
        mem_re    = 1'b1;
        mem_raddr = LAST_ROW;
        state_nxt = S_G1;
      end
      S_G1: begin
        shift_en  = 1'b1;
        chain_in  = wrap_r ? q_row : '0;
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = S_G2;
      end
      S_G2: begin
        shift_en  = 1'b1;
        first_ld  = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = RW'(1);
        y_nxt     = '0;
        state_nxt = S_GSH;
      end
      S_GSH: begin
        shift_en = 1'b1;
        if (y_r == LAST_ROW) begin
          chain_in = wrap_r ? first_row_r : '0;
        end
        state_nxt = S_GWR;
      end
      S_GWR: begin
        mem_we    = 1'b1;
        mem_waddr = y_r;
        mem_wdata = chain_out;
        if (y_r == LAST_ROW) begin
          adv_nxt   = 1'b1;
          state_nxt = S_CHK;
        end else begin
          y_nxt = y_p1;
          if (y_p1 != LAST_ROW) begin
            mem_re    = 1'b1;
            mem_raddr = y_p1 + RW'(1);
          end
          state_nxt = S_GSH;
        end
      end
      S_CHK: begin
        if (nz_cnt_r == '0) begin
          run_nxt  = 1'b0;
          dead_nxt = 1'b1;
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= 1'b0;
      tick_r      <= '0;
      period_r    <= TICKS_RESET;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
      q_vld_r     <= 1'b0;
      row_valid_r <= '0;
      row_nz_r    <= '0;
      nz_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      tick_r  <= tick_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TICKS: period_r <= cfg_wdata;
          CFG_WRAP:  wrap_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (mem_re) begin
        q_vld_r <= row_valid_r[mem_raddr];
      end
      if (mem_we) begin
        row_valid_r[mem_waddr] <= 1'b1;
        row_nz_r[mem_waddr]    <= wr_nz;
        if (wr_nz && !row_nz_r[mem_waddr]) begin
          nz_cnt_r <= nz_cnt_r + NZW'(1);
        end else if (!wr_nz && row_nz_r[mem_waddr]) begin
          nz_cnt_r <= nz_cnt_r - NZW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= cmd_t'(in_cmd);
      col_r   <= in_col;
      row_r   <= in_row;
      alive_r <= in_alive_in;
    end
    y_r    <= y_nxt;
    adv_r  <= adv_nxt;
    dead_r <= dead_nxt;
    if (first_ld) begin
      first_row_r <= q_row;
    end
    if (out_ld) begin
      out_cell_alive_r <= cell_bit;
      out_running_r    <= run_r;
      out_advanced_r   <= adv_r;
      out_all_dead_r   <= dead_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_alive_r;
  assign out_running    = out_running_r;
  assign out_advanced   = out_advanced_r;
  assign out_all_dead   = out_all_dead_r;

  `ASSERT_NEVER(a_dead_but_running, clk, rst_n, out_valid_r && out_all_dead_r && out_running_r, "all_dead word reports running")
  `ASSERT_NEVER(a_nz_count_range, clk, rst_n, nz_cnt_r > NZW'(GRID_HEIGHT), "live row count beyond grid height")
  `ASSERT_PROP(a_run_clear_cause, clk, rst_n, $past(rst_n) && $fell(run_r) |-> ($past(cmd_r) == CMD_PAUSE || $past(state_r) == S_CHK), "running cleared without pause or empty grid")

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench of the life grid generation engine: directed and random command streams
module tb;
  import lgge_pkg::*;

  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;
  localparam int GEN_CYCLES = 2 * GRID_H + 7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 225;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic cell_alive;
    logic running;
    logic advanced;
    logic all_dead;
  } life_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [COL_W-1:0] in_col = '0;
  logic [ROW_W-1:0] in_row = '0;
  logic in_alive_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_cell_alive;
  logic out_running;
  logic out_advanced;
  logic out_all_dead;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_TICKS;
  logic [TICK_W-1:0] cfg_wdata = '0;

  // predicted state of the block
  bit life_cells [GRID_H][GRID_W];
  bit model_running = 1'b0;
  bit [TICK_W-1:0] model_ticks = '0;
  bit [TICK_W-1:0] model_period = TICKS_RESET;
  bit model_wrap = 1'b0;

  life_status_t expected_words [$];
  life_status_t got_word;
  life_status_t want_word;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int unsigned cycle_count = 0;

  life_grid_generation_engine uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_col(in_col),
    .in_row(in_row),
    .in_alive_in(in_alive_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_cell_alive(out_cell_alive),
    .out_running(out_running),
    .out_advanced(out_advanced),
    .out_all_dead(out_all_dead),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int live_neighbors(int x, int y);
    int n;
    int nx;
    int ny;
    n = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dx == 0 && dy == 0) continue;
        nx = x + dx;
        ny = y + dy;
        if (model_wrap) begin
          nx = (nx + GRID_W) % GRID_W;
          ny = (ny + GRID_H) % GRID_H;
        end else if (nx < 0 || ny < 0 || nx >= GRID_W || ny >= GRID_H) begin
          continue;
        end
        n += life_cells[ny][nx];
      end
    end
    return n;
  endfunction

  function automatic void advance_grid();
    bit next_cells [GRID_H][GRID_W];
    int n;
    for (int y = 0; y < GRID_H; y++) begin
      for (int x = 0; x < GRID_W; x++) begin
        n = live_neighbors(x, y);
        next_cells[y][x] = (n == BIRTH_COUNT) || (life_cells[y][x] && n == SURVIVE_COUNT);
      end
    end
    life_cells = next_cells;
  endfunction

  function automatic bit grid_empty();
    for (int y = 0; y < GRID_H; y++) begin
      for (int x = 0; x < GRID_W; x++) begin
        if (life_cells[y][x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic life_status_t predict_word(logic [CMD_W-1:0] cmd, logic [COL_W-1:0] col,
                                                logic [ROW_W-1:0] row, logic alive);
    life_status_t st;
    bit on_grid;
    st = '0;
    on_grid = (col < GRID_W) && (row < GRID_H);
    case (cmd)
      CMD_WRITE: begin
        if (!model_running && on_grid) life_cells[row][col] = alive;
      end
      CMD_START: begin
        model_running = 1'b1;
      end
      CMD_PAUSE: begin
        if (model_running) begin
          model_running = 1'b0;
          model_ticks = '0;
        end
      end
      CMD_TICK: begin
        if (model_running) begin
          if (model_ticks != TICK_MAX) model_ticks++;
          if (model_ticks >= model_period) begin
            model_ticks = '0;
            advance_grid();
            st.advanced = 1'b1;
          end
          if (grid_empty()) begin
            model_running = 1'b0;
            st.all_dead = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    st.cell_alive = on_grid ? life_cells[row][col] : 1'b0;
    st.running = model_running;
    return st;
  endfunction

  // idle gap, then offer one word and hold it until taken
  task automatic send_word(input int cmd, input int col, input int row, input int alive);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= CMD_W'(cmd);
    in_col <= COL_W'(col);
    in_row <= ROW_W'(row);
    in_alive_in <= 1'(alive);
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(predict_word(CMD_W'(cmd), COL_W'(col), ROW_W'(row), 1'(alive)));
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic set_config(input int period, input int wrap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TICKS;
    cfg_wdata <= TICK_W'(period);
    @(posedge clk);
    model_period = TICK_W'(period);
    cfg_index <= CFG_WRAP;
    cfg_wdata <= TICK_W'(wrap);
    @(posedge clk);
    model_wrap = 1'(wrap);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 64;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 64;
      end
      default: begin
        send_idle_pct = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  task automatic test_cell_edits();
    send_word(CMD_READ, 0, 0, 1'b0);
    send_word(CMD_WRITE, 0, 0, 1'b1);
    send_word(CMD_WRITE, GRID_W - 1, GRID_H - 1, 1'b1);
    send_word(CMD_READ + 1, GRID_W - 1, GRID_H - 1, 1'b0);
    send_word(CMD_READ + 2, 0, 0, 1'b1);
    send_word(CMD_TICK, 0, 0, 1'b0);
    send_word(CMD_PAUSE, GRID_W - 1, 0, 1'b1);
  endtask

  task automatic test_run_control();
    drain_words();
    set_config(1, 1'b0);
    send_word(CMD_WRITE, 10, 5, 1'b1);
    send_word(CMD_WRITE, 11, 5, 1'b1);
    send_word(CMD_WRITE, 12, 5, 1'b1);
    send_word(CMD_START, 11, 5, 1'b0);
    send_word(CMD_START, 11, 4, 1'b0);
    send_word(CMD_WRITE, 20, 20, 1'b1);
    send_word(CMD_TICK, 11, 4, 1'b0);
    send_word(CMD_PAUSE, 11, 6, 1'b0);
  endtask

  task automatic test_edge_modes();
    drain_words();
    set_config(0, 1'b1);
    send_word(CMD_WRITE, GRID_W - 1, GRID_H - 1, 1'b1);
    send_word(CMD_WRITE, GRID_W - 1, 0, 1'b1);
    send_word(CMD_WRITE, GRID_W - 1, 1, 1'b1);
    send_word(CMD_START, 0, 0, 1'b0);
    send_word(CMD_TICK, 0, 0, 1'b0);
  endtask

  task automatic test_period_limits();
    drain_words();
    set_config(TICK_MAX, 1'b0);
    send_word(CMD_TICK, 62, 0, 1'b0);
    send_word(CMD_TICK, 63, 0, 1'b0);
    drain_words();
    // count now equal to the new period
    set_config(2, 1'b1);
    send_word(CMD_TICK, 0, 0, 1'b0);
  endtask

  task automatic test_output_backpressure();
    drain_words();
    set_idling(0);
    hold_cycles = 300;
    repeat (12) begin
      send_word($urandom_range(1) ? CMD_READ : CMD_WRITE, $urandom_range(GRID_W - 1),
                $urandom_range(GRID_H - 1), $urandom_range(1));
    end
  endtask

  task automatic test_random_runs();
    int sent;
    int episode;
    int cx;
    int cy;
    int period;
    sent = 0;
    episode = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_words();
      set_idling(episode);
      case ($urandom_range(9))
        0: period = 0;
        1: period = $urandom_range(12, 4);
        default: period = $urandom_range(3, 1);
      endcase
      set_config(period, $urandom_range(1));
      send_word(CMD_PAUSE, $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                $urandom_range(1));
      // seed a random cluster, often over an edge
      cx = $urandom_range(GRID_W - 1);
      cy = $urandom_range(GRID_H - 1);
      repeat ($urandom_range(24, 6)) begin
        if ($urandom_range(9) == 0) begin
          send_word($urandom_range(1) ? CMD_READ + $urandom_range(3) : CMD_TICK,
                    $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                    $urandom_range(1));
        end else begin
          send_word(CMD_WRITE, (cx + $urandom_range(6) + GRID_W - 3) % GRID_W,
                    (cy + $urandom_range(6) + GRID_H - 3) % GRID_H,
                    $urandom_range(9) != 0);
          sent++;
        end
      end
      send_word(CMD_START, $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                $urandom_range(1));
      sent++;
      repeat ($urandom_range(30, 8)) begin
        if (!model_running) break;
        case ($urandom_range(19))
          0: send_word(CMD_WRITE, $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                       $urandom_range(1));
          1: send_word(CMD_START, $urandom_range(GRID_W - 1), $urandom_range(GRID_H - 1),
                       $urandom_range(1));
          2: send_word(CMD_READ + $urandom_range(3), $urandom_range(GRID_W - 1),
                       $urandom_range(GRID_H - 1), $urandom_range(1));
          default: send_word(CMD_TICK, (cx + $urandom_range(8) + GRID_W - 4) % GRID_W,
                             (cy + $urandom_range(8) + GRID_H - 4) % GRID_H,
                             $urandom_range(1));
        endcase
        sent++;
      end
      episode++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_word = '{out_cell_alive, out_running, out_advanced, out_all_dead};
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected word: cell_alive=%b running=%b advanced=%b all_dead=%b",
                   got_word.cell_alive, got_word.running, got_word.advanced,
                   got_word.all_dead);
        end
      end else begin
        want_word = expected_words.pop_front();
        if (got_word !== want_word) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: expected cell_alive=%b running=%b advanced=%b all_dead=%b",
                     want_word.cell_alive, want_word.running, want_word.advanced,
                     want_word.all_dead);
            $display("          actual   cell_alive=%b running=%b advanced=%b all_dead=%b",
                     got_word.cell_alive, got_word.running, got_word.advanced,
                     got_word.all_dead);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_edits();
    test_run_control();
    test_edge_modes();
    test_period_limits();
    test_output_backpressure();
    test_random_runs();
    drain_words();
    repeat (GEN_CYCLES + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
